FILE: design/vpgmc_pkg.sv
`default_nettype none
package vpgmc_pkg;

	localparam int unsigned MS_PER_S = 1000;
	localparam int unsigned LIMIT_W = 26;

	typedef enum logic [3:0] {
		MODE_ACTIVE  = 4'b0001,
		MODE_WAITING = 4'b0010,
		MODE_ON_HOLD = 4'b0100,
		MODE_GUARD   = 4'b1000
	} mode_t;

	localparam logic [1:0] MODE_CODE_ACTIVE  = 2'd0;
	localparam logic [1:0] MODE_CODE_WAITING = 2'd1;
	localparam logic [1:0] MODE_CODE_ON_HOLD = 2'd2;
	localparam logic [1:0] MODE_CODE_GUARD   = 2'd3;

	typedef enum logic [1:0] {
		CMD_TICK      = 2'd0,
		CMD_BUTTON    = 2'd1,
		CMD_HOST_PING = 2'd2,
		CMD_HOST_HOLD = 2'd3
	} cmd_t;

	localparam logic [1:0] LEVEL_PRESSED = 2'd1;
	localparam logic [1:0] LEVEL_HELD    = 2'd2;

	typedef enum logic [2:0] {
		REG_CANCEL_BUTTON  = 3'd0,
		REG_ACCEPT_BUTTON  = 3'd1,
		REG_ACTIVE_TIMEOUT = 3'd2,
		REG_WAIT_TIMEOUT   = 3'd3,
		REG_SHUTDOWN_HOLD  = 3'd4,
		REG_GPS_CHECK      = 3'd5,
		REG_FAR_LIMIT      = 3'd6
	} reg_idx_t;

	localparam logic [3:0]  RST_CANCEL_BUTTON = 4'd0;
	localparam logic [3:0]  RST_ACCEPT_BUTTON = 4'd1;
	localparam logic [15:0] RST_ACTIVE_S      = 16'd60;
	localparam logic [15:0] RST_WAITING_S     = 16'd30;
	localparam logic [15:0] RST_SHUTDOWN_MS   = 16'd3000;
	localparam logic [15:0] RST_GPS_CHECK_MS  = 16'd1000;
	localparam logic [7:0]  RST_FAR_LIMIT     = 8'd3;

	typedef struct packed {
		logic [3:0]         cancel_button;
		logic [3:0]         accept_button;
		logic [LIMIT_W-1:0] active_limit_ms;
		logic [LIMIT_W-1:0] waiting_limit_ms;
		logic [15:0]        shutdown_hold_ms;
		logic [15:0]        gps_check_ms;
		logic [7:0]         far_count_limit;
	} cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic [31:0] mode_age_ms;
		logic        hold_armed;
		logic [15:0] hold_age_ms;
		logic [15:0] check_age_ms;
		logic        reference_valid;
		logic [7:0]  far_count;
	} state_t;

	typedef struct packed {
		cmd_t       command;
		logic [3:0] button_id;
		logic [1:0] button_level;
		logic       fix_valid;
		logic       fix_far;
	} item_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       relay_on;
		logic       pass_button;
		logic       shutdown_pulse;
		logic       ping_reply;
		logic       capture_reference;
	} result_t;

	function automatic logic [LIMIT_W-1:0] sec_to_ms(input logic [15:0] sec);
		return LIMIT_W'(sec) * LIMIT_W'(MS_PER_S);
	endfunction

	function automatic logic [1:0] mode_code(input mode_t m);
		logic [1:0] code;
		unique case (m)
			MODE_ACTIVE:  code = MODE_CODE_ACTIVE;
			MODE_WAITING: code = MODE_CODE_WAITING;
			MODE_ON_HOLD: code = MODE_CODE_ON_HOLD;
			MODE_GUARD:   code = MODE_CODE_GUARD;
			default:      code = MODE_CODE_GUARD;
		endcase
		return code;
	endfunction

endpackage
`default_nettype wire

FILE: design/vpgmc_step.sv
`default_nettype none
module vpgmc_step
	import vpgmc_pkg::*;
(
	input  wire cfg_t    cfg,
	input  wire state_t  cur,
	input  wire item_t   item,
	output state_t       nxt,
	output result_t      res
);

	always_comb begin
		logic [31:0] age_inc;
		logic [15:0] check_inc;
		logic [15:0] hold_inc;
		logic [7:0]  fc;
		logic        is_cancel;
		logic        is_accept;
		logic        pressed;
		logic        leave;
		mode_t       target;
		logic        change;
		logic        pass;
		logic        pulse;
		logic        ping;
		logic        capture;

		nxt       = cur;
		age_inc   = (cur.mode_age_ms != 32'hFFFF_FFFF) ? cur.mode_age_ms + 32'd1 : cur.mode_age_ms;
		check_inc = (cur.check_age_ms != 16'hFFFF) ? cur.check_age_ms + 16'd1 : cur.check_age_ms;
		hold_inc  = (cur.hold_age_ms != 16'hFFFF) ? cur.hold_age_ms + 16'd1 : cur.hold_age_ms;
		fc        = cur.far_count;
		is_cancel = item.button_id == cfg.cancel_button;
		is_accept = item.button_id == cfg.accept_button;
		pressed   = item.button_level == LEVEL_PRESSED;
		leave     = 1'b0;
		target    = cur.mode;
		change    = 1'b0;
		pass      = 1'b0;
		pulse     = 1'b0;
		ping      = 1'b0;
		capture   = 1'b0;

		unique case (item.command)
			CMD_TICK: begin
				nxt.mode_age_ms  = age_inc;
				nxt.check_age_ms = check_inc;
				if (cur.hold_armed) begin
					nxt.hold_age_ms = hold_inc;
				end
				if (cur.mode == MODE_ACTIVE) begin
					if (age_inc > 32'(cfg.active_limit_ms)) begin
						target = MODE_WAITING;
						change = 1'b1;
					end
				end else if (cur.mode == MODE_WAITING) begin
					if (age_inc > 32'(cfg.waiting_limit_ms)) begin
						target = MODE_GUARD;
						change = 1'b1;
					end
				end else if (cur.mode == MODE_GUARD) begin
					if (check_inc > cfg.gps_check_ms) begin
						nxt.check_age_ms = '0;
						if (item.fix_valid) begin
							if (cur.reference_valid) begin
								if (item.fix_far) begin
									fc = (cur.far_count != 8'hFF) ? cur.far_count + 8'd1 :
										cur.far_count;
								end else begin
									fc = '0;
								end
								nxt.far_count = fc;
								leave = fc >= cfg.far_count_limit;
							end else begin
								nxt.reference_valid = 1'b1;
								nxt.far_count       = '0;
								capture             = 1'b1;
							end
						end
					end
					if (leave) begin
						target = MODE_WAITING;
						change = 1'b1;
					end
				end
			end
			CMD_BUTTON: begin
				if (is_cancel && item.button_level == LEVEL_HELD && cur.mode == MODE_ACTIVE) begin
					if (!cur.hold_armed) begin
						nxt.hold_armed  = 1'b1;
						nxt.hold_age_ms = '0;
					end else if (cur.hold_age_ms > cfg.shutdown_hold_ms) begin
						nxt.hold_armed  = 1'b0;
						nxt.hold_age_ms = '0;
						pulse           = 1'b1;
					end
				end else begin
					nxt.hold_armed  = 1'b0;
					nxt.hold_age_ms = '0;
				end
				unique case (cur.mode)
					MODE_WAITING: begin
						if (is_cancel && pressed) begin
							target = MODE_GUARD;
							change = 1'b1;
						end else if (is_accept && pressed) begin
							target = MODE_ON_HOLD;
							change = 1'b1;
						end
					end
					MODE_ON_HOLD: begin
						if (is_cancel && pressed) begin
							target = MODE_GUARD;
							change = 1'b1;
						end
					end
					MODE_GUARD: begin
						if (is_accept && pressed) begin
							target = MODE_WAITING;
							change = 1'b1;
						end
					end
					default: pass = 1'b1;
				endcase
			end
			CMD_HOST_PING: begin
				target = MODE_ACTIVE;
				change = 1'b1;
				ping   = 1'b1;
			end
			CMD_HOST_HOLD: begin
				target = MODE_ON_HOLD;
				change = 1'b1;
			end
			default: ;
		endcase

		if (change) begin
			nxt.mode        = target;
			nxt.mode_age_ms = '0;
			if (target == MODE_GUARD) begin
				nxt.reference_valid = 1'b0;
			end
		end

		res.mode              = mode_code(nxt.mode);
		res.relay_on          = nxt.mode != MODE_GUARD;
		res.pass_button       = pass;
		res.shutdown_pulse    = pulse;
		res.ping_reply        = ping;
		res.capture_reference = capture;
	end

endmodule
`default_nettype wire

FILE: design/vehicle_power_guard_mode_controller_core.sv
// The accepted item is registered in the input stage, its result in the output stage.
// One item per cycle unless the output stalls; mode and timer state update in a single pass.
// A stalled result holds one more transaction in the input register, then tready drops.
// Reset (arst_n low, asynchronous): guard mode, all timers and counters zero,
// no reference, registers at their default values, both stages empty.
`default_nettype none
module vehicle_power_guard_mode_controller_core
	import vpgmc_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire [2:0]  cfg_index,
	input  wire [15:0] cfg_data,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [7:0]  s_axis_tdata,   // button_id[3:0], button_level[5:4], fix_valid[6], fix_far[7]
	input  wire [1:0]  s_axis_tuser,   // command[1:0]
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [7:0] m_axis_tdata    // mode[1:0], relay_on, pass_button, shutdown_pulse,
	                                   // ping_reply, capture_reference, zero pad
);

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_nxt;
	result_t res_s2;
	logic    advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cancel_button    <= RST_CANCEL_BUTTON;
			cfg_q.accept_button    <= RST_ACCEPT_BUTTON;
			cfg_q.active_limit_ms  <= sec_to_ms(RST_ACTIVE_S);
			cfg_q.waiting_limit_ms <= sec_to_ms(RST_WAITING_S);
			cfg_q.shutdown_hold_ms <= RST_SHUTDOWN_MS;
			cfg_q.gps_check_ms     <= RST_GPS_CHECK_MS;
			cfg_q.far_count_limit  <= RST_FAR_LIMIT;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CANCEL_BUTTON:  cfg_q.cancel_button    <= cfg_data[3:0];
				REG_ACCEPT_BUTTON:  cfg_q.accept_button    <= cfg_data[3:0];
				REG_ACTIVE_TIMEOUT: cfg_q.active_limit_ms  <= sec_to_ms(cfg_data);
				REG_WAIT_TIMEOUT:   cfg_q.waiting_limit_ms <= sec_to_ms(cfg_data);
				REG_SHUTDOWN_HOLD:  cfg_q.shutdown_hold_ms <= cfg_data;
				REG_GPS_CHECK:      cfg_q.gps_check_ms     <= cfg_data;
				REG_FAR_LIMIT:      cfg_q.far_count_limit  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.command      <= cmd_t'(s_axis_tuser);
			item_s1.button_id    <= s_axis_tdata[3:0];
			item_s1.button_level <= s_axis_tdata[5:4];
			item_s1.fix_valid    <= s_axis_tdata[6];
			item_s1.fix_far      <= s_axis_tdata[7];
		end
	end

	vpgmc_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode            <= MODE_GUARD;
			state_q.mode_age_ms     <= '0;
			state_q.hold_armed      <= 1'b0;
			state_q.hold_age_ms     <= '0;
			state_q.check_age_ms    <= '0;
			state_q.reference_valid <= 1'b0;
			state_q.far_count       <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (!m_axis_tvalid || m_axis_tready) begin
			m_axis_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_axis_tdata = {1'b0, res_s2.capture_reference, res_s2.ping_reply,
		res_s2.shutdown_pulse, res_s2.pass_button, res_s2.relay_on, res_s2.mode};

endmodule
`default_nettype wire

FILE: design/vpgmc_checker.sv
`default_nettype none
module vpgmc_checker
	import vpgmc_pkg::*;
(
	input wire       clk,
	input wire       arst_n,
	input wire       m_axis_tvalid,
	input wire       m_axis_tready,
	input wire [7:0] m_axis_tdata
);

	// relay is off exactly in guard
	a_relay_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2] == (m_axis_tdata[1:0] != MODE_CODE_GUARD)))
		else $error("relay_on disagrees with mode");

	a_ping_active: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[5]) |->
			(m_axis_tdata[1:0] == MODE_CODE_ACTIVE && !m_axis_tdata[3] && !m_axis_tdata[6]))
		else $error("ping reply outside active mode");

	a_capture_guard: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[6]) |->
			(m_axis_tdata[1:0] == MODE_CODE_GUARD && !m_axis_tdata[3] && !m_axis_tdata[4]))
		else $error("reference capture outside guard");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled output transaction changed");

endmodule

bind vehicle_power_guard_mode_controller_core vpgmc_checker u_vpgmc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
